// ===== sv/mcsr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the machine-mode csr file
// no dependencies; used by every module of the block

package mcsr_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0]  OPC_SYSTEM   = 7'h73;
   localparam logic [11:0] ADDR_MSTATUS  = 12'h300;
   localparam logic [11:0] ADDR_MISA     = 12'h301;
   localparam logic [11:0] ADDR_MTVEC    = 12'h305;
   localparam logic [11:0] ADDR_MSCRATCH = 12'h340;
   localparam logic [11:0] ADDR_MEPC     = 12'h341;
   localparam logic [11:0] ADDR_MCAUSE   = 12'h342;
   localparam logic [11:0] ADDR_MTVAL    = 12'h343;

   localparam logic [XLEN-1:0] MISA_VALUE    = 32'h4000_1100;
   localparam logic [XLEN-1:0] MSTATUS_MIE   = 32'h0000_0008;
   localparam logic [XLEN-1:0] MSTATUS_MPIE  = 32'h0000_0080;
   localparam logic [XLEN-1:0] MSTATUS_MPP_M = 32'h0000_1800;
   localparam logic [XLEN-1:0] ALIGN_MASK    = 32'hFFFF_FFFC;

   typedef enum logic [2:0] {
      ERR_OK       = 3'd0,
      ERR_NOT_CSR  = 3'd1,
      ERR_FUNCT3   = 3'd2,
      ERR_NO_CSR   = 3'd3,
      ERR_READONLY = 3'd4
   } err_type;

   // low two bits of funct3
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_RW   = 2'd1,
      OP_RS   = 2'd2,
      OP_RC   = 2'd3
   } csr_op_type;

   typedef enum logic [2:0] {
      SEL_MSTATUS,
      SEL_MISA,
      SEL_MTVEC,
      SEL_MSCRATCH,
      SEL_MEPC,
      SEL_MCAUSE,
      SEL_MTVAL
   } csr_sel_type;

   // classified transaction handed from decode to execute
   typedef struct packed {
      logic [XLEN-1:0] next_pc;
      logic [4:0]      rd;
      csr_sel_type     sel;
      csr_op_type      op;
      logic            wr;
      logic [XLEN-1:0] src;
      err_type         err;
   } decoded_type;

endpackage

// ===== sv/mcsr_decode.sv =====
`timescale 1ns / 1ps
// front end: splits the instruction word and classifies errors
// depends on mcsr_pkg

module mcsr_decode (
   input  logic [mcsr_pkg::XLEN-1:0] pc,
   input  logic [mcsr_pkg::XLEN-1:0] instruction,
   input  logic [mcsr_pkg::XLEN-1:0] source_value,
   output mcsr_pkg::decoded_type     decoded
);

   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [4:0]  rs1_field;
   logic [11:0] csr_addr;
   logic        csr_known;
   mcsr_pkg::csr_sel_type csr_sel;
   mcsr_pkg::csr_op_type  op;
   logic        wr_intent;

   assign opcode    = instruction[6:0];
   assign funct3    = instruction[14:12];
   assign rs1_field = instruction[19:15];
   assign csr_addr  = instruction[31:20];
   assign op        = mcsr_pkg::csr_op_type'(funct3[1:0]);
   // set/clear with a zero source field only reads
   assign wr_intent = (op == mcsr_pkg::OP_RW) || (rs1_field != 5'd0);

   always_comb begin
      csr_known = 1'b1;
      unique case (csr_addr)
         mcsr_pkg::ADDR_MSTATUS:  csr_sel = mcsr_pkg::SEL_MSTATUS;
         mcsr_pkg::ADDR_MISA:     csr_sel = mcsr_pkg::SEL_MISA;
         mcsr_pkg::ADDR_MTVEC:    csr_sel = mcsr_pkg::SEL_MTVEC;
         mcsr_pkg::ADDR_MSCRATCH: csr_sel = mcsr_pkg::SEL_MSCRATCH;
         mcsr_pkg::ADDR_MEPC:     csr_sel = mcsr_pkg::SEL_MEPC;
         mcsr_pkg::ADDR_MCAUSE:   csr_sel = mcsr_pkg::SEL_MCAUSE;
         mcsr_pkg::ADDR_MTVAL:    csr_sel = mcsr_pkg::SEL_MTVAL;
         default: begin
            csr_sel   = mcsr_pkg::SEL_MSTATUS;
            csr_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      decoded.next_pc = pc + 32'd4;
      decoded.rd      = instruction[11:7];
      decoded.sel     = csr_sel;
      decoded.op      = op;
      decoded.wr      = wr_intent;
      decoded.src     = funct3[2] ? {27'd0, rs1_field} : source_value;
      if (opcode != mcsr_pkg::OPC_SYSTEM || funct3 == 3'd0) begin
         decoded.err = mcsr_pkg::ERR_NOT_CSR;
      end else if (op == mcsr_pkg::OP_NONE) begin
         decoded.err = mcsr_pkg::ERR_FUNCT3;
      end else if (!csr_known) begin
         decoded.err = mcsr_pkg::ERR_NO_CSR;
      end else if (wr_intent && csr_sel == mcsr_pkg::SEL_MISA) begin
         decoded.err = mcsr_pkg::ERR_READONLY;
      end else begin
         decoded.err = mcsr_pkg::ERR_OK;
      end
   end

endmodule

// ===== sv/mcsr_queue.sv =====
`timescale 1ns / 1ps
// small fifo of decoded transactions between decode and execute
// depends on mcsr_pkg

module mcsr_queue #(
   parameter int unsigned DEPTH = mcsr_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mcsr_pkg::decoded_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output mcsr_pkg::decoded_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   mcsr_pkg::decoded_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/mcsr_exec.sv =====
`timescale 1ns / 1ps
// back end: csr registers, read-modify-write and the result register
// depends on mcsr_pkg

module mcsr_exec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  mcsr_pkg::decoded_type         head,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mcsr_pkg::XLEN-1:0]     rsp_next_pc,
   output logic [4:0]                    rsp_dest_reg,
   output logic                          rsp_dest_write,
   output logic [mcsr_pkg::XLEN-1:0]     rsp_dest_value,
   output logic [2:0]                    rsp_error_code
);

   logic [mcsr_pkg::XLEN-1:0] mstatus_ff, mtvec_ff, mscratch_ff;
   logic [mcsr_pkg::XLEN-1:0] mepc_ff, mcause_ff, mtval_ff;
   logic [mcsr_pkg::XLEN-1:0] read_value, old_value, new_value;
   logic                      ok, commit;

   logic                      valid_ff;
   logic [mcsr_pkg::XLEN-1:0] next_pc_ff, dest_value_ff;
   logic [4:0]                dest_reg_ff;
   logic                      dest_write_ff;
   mcsr_pkg::err_type         err_ff;

   // result register can take a new transaction when empty or draining
   assign head_pop = head_valid && (!valid_ff || rsp_ready);
   assign ok       = (head.err == mcsr_pkg::ERR_OK);
   assign commit   = head_pop && ok && head.wr;

   always_comb begin
      unique case (head.sel)
         mcsr_pkg::SEL_MSTATUS:  read_value = mstatus_ff;
         mcsr_pkg::SEL_MISA:     read_value = mcsr_pkg::MISA_VALUE;
         mcsr_pkg::SEL_MTVEC:    read_value = mtvec_ff;
         mcsr_pkg::SEL_MSCRATCH: read_value = mscratch_ff;
         mcsr_pkg::SEL_MEPC:     read_value = mepc_ff;
         mcsr_pkg::SEL_MCAUSE:   read_value = mcause_ff;
         mcsr_pkg::SEL_MTVAL:    read_value = mtval_ff;
         default:                read_value = '0;
      endcase
   end

   assign old_value = ok ? read_value : '0;

   always_comb begin
      case (head.op)
         mcsr_pkg::OP_RS: new_value = old_value | head.src;
         mcsr_pkg::OP_RC: new_value = old_value & ~head.src;
         default:         new_value = head.src;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstatus_ff  <= '0;
         mtvec_ff    <= '0;
         mscratch_ff <= '0;
         mepc_ff     <= '0;
         mcause_ff   <= '0;
         mtval_ff    <= '0;
      end else if (commit) begin
         case (head.sel)
            mcsr_pkg::SEL_MSTATUS:
               mstatus_ff <= (new_value & (mcsr_pkg::MSTATUS_MIE | mcsr_pkg::MSTATUS_MPIE))
                             | mcsr_pkg::MSTATUS_MPP_M;
            mcsr_pkg::SEL_MTVEC:    mtvec_ff    <= new_value & mcsr_pkg::ALIGN_MASK;
            mcsr_pkg::SEL_MSCRATCH: mscratch_ff <= new_value;
            mcsr_pkg::SEL_MEPC:     mepc_ff     <= new_value & mcsr_pkg::ALIGN_MASK;
            mcsr_pkg::SEL_MCAUSE:   mcause_ff   <= new_value;
            mcsr_pkg::SEL_MTVAL:    mtval_ff    <= new_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (head_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         next_pc_ff    <= head.next_pc;
         dest_reg_ff   <= head.rd;
         dest_write_ff <= ok && (head.rd != 5'd0);
         dest_value_ff <= old_value;
         err_ff        <= head.err;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_next_pc    = next_pc_ff;
   assign rsp_dest_reg   = dest_reg_ff;
   assign rsp_dest_write = dest_write_ff;
   assign rsp_dest_value = dest_value_ff;
   assign rsp_error_code = err_ff;

endmodule

// ===== sv/machine_csr_file_zicsr.sv =====
`timescale 1ns / 1ps
// Machine-mode Zicsr csr file (mstatus, misa, mtvec, mscratch, mepc, mcause, mtval).
// Takes one transaction per cycle while the response side keeps up and presents its result
// after it has passed through the queue and then the result register; the throughput is
// set by the execute stage, which does the whole csr read-modify-write as it pops the
// queue head. A QUEUE_DEPTH-entry queue between decode and execute absorbs response
// stalls; req_ready drops only when it is full. Errors leave all csrs unchanged and
// return a zero dest value.
// Depends on mcsr_pkg, mcsr_decode, mcsr_queue and mcsr_exec.

module machine_csr_file_zicsr #(
   parameter int unsigned QUEUE_DEPTH = mcsr_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mcsr_pkg::XLEN-1:0] req_pc,
   input  logic [mcsr_pkg::XLEN-1:0] req_instruction,
   input  logic [mcsr_pkg::XLEN-1:0] req_source_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mcsr_pkg::XLEN-1:0] rsp_next_pc,
   output logic [4:0]                rsp_dest_reg,
   output logic                      rsp_dest_write,
   output logic [mcsr_pkg::XLEN-1:0] rsp_dest_value,
   output logic [2:0]                rsp_error_code
);

   mcsr_pkg::decoded_type decoded, head;
   logic queue_full, head_valid, head_pop;

   mcsr_decode u_decode (
      .pc           (req_pc),
      .instruction  (req_instruction),
      .source_value (req_source_value),
      .decoded      (decoded)
   );

   mcsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (decoded),
      .full      (queue_full),
      .pop       (head_pop),
      .not_empty (head_valid),
      .head      (head)
   );

   assign req_ready = !queue_full;

   mcsr_exec u_exec (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_dest_reg   (rsp_dest_reg),
      .rsp_dest_write (rsp_dest_write),
      .rsp_dest_value (rsp_dest_value),
      .rsp_error_code (rsp_error_code)
   );

   // an error result never writes rd and carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != mcsr_pkg::ERR_OK |-> !rsp_dest_write && rsp_dest_value == '0)
      else $error("error result writes rd or carries data");

   // x0 is never written
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_reg == 5'd0 |-> !rsp_dest_write)
      else $error("write enable set for x0");

   // with the queue empty and the result register free, an accepted transaction is presented
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !head_valid && (!rsp_valid || rsp_ready) |=> ##1 rsp_valid)
      else $error("transaction not forwarded to result register");

endmodule
